// File: src/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: label");

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed: label");

`endif

// File: src/ssd_pkg.sv
// Shared types, codes and the character-to-segment table of the scan driver.
// Depends on nothing.
package ssd_pkg;

    localparam int unsigned PERIOD_W = 12;
    localparam int unsigned DIGIT_W  = 2;
    localparam int unsigned SLOTS    = 4;
    localparam int unsigned KIND_W   = 3;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 12'd3750;
    localparam logic [7:0]          POINT_BIT    = 8'h80;
    localparam logic [7:0]          SEG_MASK     = 8'h7f;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK      = 3'd0,
        KIND_SET_CHAR  = 3'd1,
        KIND_POINT_ON  = 3'd2,
        KIND_POINT_OFF = 3'd3,
        KIND_CLEAR_ALL = 3'd4
    } t_kind;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [7:0]         character;
        logic [DIGIT_W-1:0] digit;
    } t_item;

    // Input register contents as seen by the engine
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_stage;

    typedef struct packed {
        logic [7:0]         segments;
        logic [SLOTS-1:0]   digit_enable;
        logic [DIGIT_W-1:0] digit_index;
    } t_result;

    // Result handoff from the engine to the output register
    typedef struct packed {
        logic    load;
        t_result data;
    } t_res_ctl;

    // Segment pattern gfedcba for an ASCII code; blank if not in the table
    function automatic logic [6:0] glyph_lookup(input logic [7:0] ch);
        logic [6:0] pat;
        case (ch)
            8'h30:   pat = 7'h3f;
            8'h31:   pat = 7'h06;
            8'h32:   pat = 7'h5b;
            8'h33:   pat = 7'h4f;
            8'h34:   pat = 7'h66;
            8'h35:   pat = 7'h6d;
            8'h36:   pat = 7'h7d;
            8'h37:   pat = 7'h07;
            8'h38:   pat = 7'h7f;
            8'h39:   pat = 7'h6f;
            8'h2a:   pat = 7'h46;
            8'h23:   pat = 7'h70;
            8'h61:   pat = 7'h77;
            8'h62:   pat = 7'h7c;
            8'h63:   pat = 7'h39;
            8'h64:   pat = 7'h5e;
            8'h65:   pat = 7'h79;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

endpackage

// File: src/ssd_if.sv
// Valid/ready channel interfaces for items in and results out.
// Depends on nothing.
interface ssd_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] character;
    logic [1:0] digit;

    modport source (output valid, output kind, output character, output digit, input ready);
    modport sink   (input valid, input kind, input character, input digit, output ready);
endinterface

interface ssd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] segments;
    logic [3:0] digit_enable;
    logic [1:0] digit_index;

    modport source (output valid, output segments, output digit_enable, output digit_index,
                    input ready);
    modport sink   (input valid, input segments, input digit_enable, input digit_index,
                    output ready);
endinterface

// File: src/ssd_in_stage.sv
// Input register of the scan driver: holds one accepted item for the engine.
// Depends on ssd_pkg and ssd_item_if.
module ssd_in_stage import ssd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ssd_item_if.sink         i_item,
    input  logic             i_advance,
    output t_stage           o_stage
);

    logic  r_valid;
    t_item r_item;

    // Take a new item when empty or when the held one moves on
    assign i_item.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item.kind      <= i_item.kind;
            r_item.character <= i_item.character;
            r_item.digit     <= i_item.digit;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

// File: src/ssd_engine.sv
// Digit store, tick counter and scan index; applies one staged item a cycle unless a refreshing tick is stalled.
// Depends on ssd_pkg.
module ssd_engine import ssd_pkg::*; #(
    parameter int NUM_DIGITS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [PERIOD_W-1:0] i_cfg_wdata,
    input  t_stage              i_stage,
    input  logic                i_slot_free,
    output logic                o_advance,
    output t_res_ctl            o_res
);

    localparam logic [3:0] NUM_D = 4'(NUM_DIGITS);

    logic [7:0]          r_codes [SLOTS];
    logic [DIGIT_W-1:0]  r_scan;
    logic [PERIOD_W-1:0] r_count;
    logic [PERIOD_W-1:0] r_period;

    logic [PERIOD_W:0]   next_count;
    logic                is_tick;
    logic                hit;
    logic                apply;
    logic                d_ok;
    logic [DIGIT_W-1:0]  idx_cur;
    logic [DIGIT_W:0]    idx_inc;
    logic [DIGIT_W-1:0]  n_scan;
    logic [6:0]          glyph;

    // Tick compare against the scan period
    assign is_tick    = (i_stage.item.kind == KIND_TICK);
    assign next_count = {1'b0, r_count} + 13'd1;
    assign hit        = i_stage.valid && is_tick && (next_count >= {1'b0, r_period});

    // Stall only a refreshing tick while the result register is full
    assign o_advance = !hit || i_slot_free;
    assign apply     = i_stage.valid && o_advance;

    // Current digit and the one after it, wrapping at the digit count
    assign idx_cur = ({2'b00, r_scan} < NUM_D) ? r_scan : '0;
    assign idx_inc = {1'b0, idx_cur} + 3'd1;
    assign n_scan  = ({1'b0, idx_inc} >= NUM_D) ? '0 : idx_inc[DIGIT_W-1:0];

    assign d_ok  = ({2'b00, i_stage.item.digit} < NUM_D);
    assign glyph = glyph_lookup(i_stage.item.character);

    // Result for the output register
    assign o_res.load              = hit && i_slot_free;
    assign o_res.data.segments     = r_codes[idx_cur];
    assign o_res.data.digit_enable = ~(4'b0001 << idx_cur);
    assign o_res.data.digit_index  = idx_cur;

    // Scan period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    // Advance tick counter and scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_scan  <= '0;
        end else if (apply && is_tick) begin
            if (hit) begin
                r_count <= '0;
                r_scan  <= n_scan;
            end else begin
                r_count <= next_count[PERIOD_W-1:0];
            end
        end
    end

    // Update the digit store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_codes[i] <= '0;
            end
        end else if (apply) begin
            case (i_stage.item.kind)
                KIND_SET_CHAR: begin
                    if (d_ok) begin
                        r_codes[i_stage.item.digit] <= {r_codes[i_stage.item.digit][7], glyph};
                    end
                end
                KIND_POINT_ON: begin
                    if (d_ok) begin
                        r_codes[i_stage.item.digit] <= r_codes[i_stage.item.digit] | POINT_BIT;
                    end
                end
                KIND_POINT_OFF: begin
                    if (d_ok) begin
                        r_codes[i_stage.item.digit] <= r_codes[i_stage.item.digit] & SEG_MASK;
                    end
                end
                KIND_CLEAR_ALL: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        r_codes[i] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: src/ssd_out_stage.sv
// Result register of the scan driver: holds one refresh until it is taken.
// Depends on ssd_pkg and ssd_result_if.
module ssd_out_stage import ssd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_res_ctl    i_res,
    output logic        o_slot_free,
    ssd_result_if.source o_result
);

    logic    r_valid;
    t_result r_data;

    assign o_slot_free = !r_valid || o_result.ready;

    // Hold the result until taken, load a new one when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_slot_free) begin
            r_valid <= i_res.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.load) begin
            r_data <= i_res.data;
        end
    end

    assign o_result.valid        = r_valid;
    assign o_result.segments     = r_data.segments;
    assign o_result.digit_enable = r_data.digit_enable;
    assign o_result.digit_index  = r_data.digit_index;

endmodule

// File: src/seven_segment_scan_driver_core.sv
// Multiplexed four-digit seven-segment driver. Takes one item per clock
// (tick, set character, point on/off, clear all); each item passes the input
// register and then updates the digit store or tick counter; a tick that
// reaches the scan period loads the result register at the same edge as it
// clears the tick counter, so a refresh passes the input and result registers
// before it appears on the result port. The only stall is a refreshing tick held
// in the input register while the result register is still full.
// Depends on ssd_pkg, ssd_if, ssd_in_stage, ssd_engine and ssd_out_stage.
module seven_segment_scan_driver_core import ssd_pkg::*; #(
    parameter int NUM_DIGITS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [PERIOD_W-1:0] i_cfg_wdata,
    ssd_item_if.sink            i_item,
    ssd_result_if.source        o_result
);

    t_stage   stage;
    t_res_ctl res;
    logic     advance;
    logic     slot_free;

    ssd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_advance (advance),
        .o_stage   (stage)
    );

    ssd_engine #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stage     (stage),
        .i_slot_free (slot_free),
        .o_advance   (advance),
        .o_res       (res)
    );

    ssd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (res),
        .o_slot_free (slot_free),
        .o_result    (o_result)
    );

endmodule

// File: src/ssd_checker.sv
// Port-level checks of the scan driver, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ssd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_digit_enable,
    input logic [1:0] i_digit_index
);

    // A refresh drives exactly one digit
    `ASSERT_CLK(a_one_cold, i_clk, i_rst_n, i_out_valid |-> ($countones(~i_digit_enable) == 1))

    // The enabled digit is the one the index names
    `ASSERT_CLK(a_index_match, i_clk, i_rst_n, i_out_valid |-> (i_digit_enable[i_digit_index] == 1'b0))

    // No result right after reset
    `ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !i_out_valid)

    // A waiting result stays offered
    `ASSERT_CLK(a_valid_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid)

endmodule

bind seven_segment_scan_driver_core ssd_checker u_ssd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_digit_enable (o_result.digit_enable),
    .i_digit_index  (o_result.digit_index)
);

// File: bench/tb_seven_segment_scan_driver_core.sv
// Self-checking bench for the four-digit seven-segment scan driver.
// Predicts each refresh from the accepted items and checks it field by field.
// Depends on ssd_pkg, ssd_if and seven_segment_scan_driver_core.
`timescale 1ns / 1ps

module tb_seven_segment_scan_driver_core;
    import ssd_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNKNOWN_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN_MID   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN_LAST  = 3'd7;
    localparam int                SETTLE_CYCLES      = 4;
    localparam int                DRAIN_LIMIT        = 100000;
    localparam int                PHASE_ITEMS        = 200;
    localparam int                NUM_PHASES         = 8;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX       = 12'd4095;

    // Predicts refreshes and holds the ones not yet seen on the output
    class refresh_scoreboard;
        logic [7:0]          digit_codes [SLOTS];
        logic [DIGIT_W-1:0]  scan_idx;
        logic [PERIOD_W-1:0] tick_cnt;
        logic [PERIOD_W-1:0] scan_period;
        t_result             pending_refreshes [$];
        int unsigned         error_count;
        int unsigned         item_count;
        int unsigned         tick_items;
        int unsigned         refresh_count;

        function new();
            foreach (digit_codes[i]) digit_codes[i] = '0;
            scan_idx      = '0;
            tick_cnt      = '0;
            scan_period   = PERIOD_RESET;
            error_count   = 0;
            item_count    = 0;
            tick_items    = 0;
            refresh_count = 0;
        endfunction

        function void set_period(logic [PERIOD_W-1:0] value);
            scan_period = value;
        endfunction

        function int pending();
            return pending_refreshes.size();
        endfunction

        // Segment pattern gfedcba for a character; blank when not shown
        function logic [6:0] glyph_of(logic [7:0] ch);
            case (ch)
                "0": return 7'h3f;
                "1": return 7'h06;
                "2": return 7'h5b;
                "3": return 7'h4f;
                "4": return 7'h66;
                "5": return 7'h6d;
                "6": return 7'h7d;
                "7": return 7'h07;
                "8": return 7'h7f;
                "9": return 7'h6f;
                "*": return 7'h46;
                "#": return 7'h70;
                "a": return 7'h77;
                "b": return 7'h7c;
                "c": return 7'h39;
                "d": return 7'h5e;
                "e": return 7'h79;
                default: return 7'h00;
            endcase
        endfunction

        task report_mismatch(string msg);
            error_count++;
            if (error_count <= 40) $display("MISMATCH: %s", msg);
        endtask

        // Update the digit store or tick counter for one accepted item
        function void note_item(logic [KIND_W-1:0] kind, logic [7:0] ch,
                                logic [DIGIT_W-1:0] d);
            logic [PERIOD_W:0] next_cnt;
            t_result           r;
            item_count++;
            case (kind)
                KIND_TICK: begin
                    tick_items++;
                    next_cnt = {1'b0, tick_cnt} + 1'b1;
                    if (next_cnt < {1'b0, scan_period}) begin
                        tick_cnt = next_cnt[PERIOD_W-1:0];
                    end else begin
                        tick_cnt              = '0;
                        r.segments            = digit_codes[scan_idx];
                        r.digit_enable        = '1;
                        r.digit_enable[scan_idx] = 1'b0;
                        r.digit_index         = scan_idx;
                        pending_refreshes.push_back(r);
                        scan_idx = (scan_idx == SLOTS - 1) ? '0 : scan_idx + 1'b1;
                    end
                end
                KIND_SET_CHAR: begin
                    digit_codes[d] = {digit_codes[d][7], glyph_of(ch)};
                end
                KIND_POINT_ON: begin
                    digit_codes[d] = digit_codes[d] | POINT_BIT;
                end
                KIND_POINT_OFF: begin
                    digit_codes[d] = digit_codes[d] & SEG_MASK;
                end
                KIND_CLEAR_ALL: begin
                    foreach (digit_codes[i]) digit_codes[i] = '0;
                end
                default: ;
            endcase
        endfunction

        // Compare one accepted refresh with the oldest prediction
        task check_refresh(t_result got);
            t_result want;
            if (pending_refreshes.size() == 0) begin
                report_mismatch($sformatf("refresh with no tick pending: seg %h en %h idx %0d",
                                          got.segments, got.digit_enable, got.digit_index));
            end else begin
                want = pending_refreshes.pop_front();
                refresh_count++;
                if (got.segments !== want.segments)
                    report_mismatch($sformatf("segments got %h want %h",
                                              got.segments, want.segments));
                if (got.digit_enable !== want.digit_enable)
                    report_mismatch($sformatf("digit_enable got %b want %b",
                                              got.digit_enable, want.digit_enable));
                if (got.digit_index !== want.digit_index)
                    report_mismatch($sformatf("digit_index got %0d want %0d",
                                              got.digit_index, want.digit_index));
            end
        endtask

        task flush_leftovers();
            t_result want;
            while (pending_refreshes.size() != 0) begin
                want = pending_refreshes.pop_front();
                report_mismatch($sformatf("refresh never seen: seg %h idx %0d",
                                          want.segments, want.digit_index));
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [PERIOD_W-1:0] i_cfg_wdata;

    ssd_item_if   item_if ();
    ssd_result_if res_if ();

    refresh_scoreboard refresh_sb;

    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;
    int unsigned rx_hold_off;
    int unsigned period_writes;

    logic [7:0] glyph_chars [18] = '{"0", "1", "2", "3", "4", "5", "6", "7", "8",
                                     "9", "*", "#", "a", "b", "c", "d", "e", " "};

    seven_segment_scan_driver_core #(
        .NUM_DIGITS (SLOTS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_if),
        .o_result    (res_if)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop if the run hangs
    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receive refreshes: check on acceptance, then pick ready for the next edge
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready)
                refresh_sb.check_refresh('{segments:     res_if.segments,
                                           digit_enable: res_if.digit_enable,
                                           digit_index:  res_if.digit_index});
            if (rx_hold_off > 0) begin
                rx_hold_off--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // Offer one item and hold it until the block takes it
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [7:0] ch,
                           input logic [DIGIT_W-1:0] d);
        item_if.valid     <= 1'b1;
        item_if.kind      <= kind;
        item_if.character <= ch;
        item_if.digit     <= d;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        refresh_sb.note_item(kind, ch, d);
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count) send_op(KIND_TICK, 8'($urandom_range(0, 255)),
                               DIGIT_W'($urandom_range(0, 3)));
    endtask

    // Drop valid and wait until every predicted refresh has come out
    task automatic pause_sender();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (refresh_sb.pending() != 0) @(posedge i_clk);
    endtask

    // Write the scan period once the block has gone quiet
    task automatic write_period(input logic [PERIOD_W-1:0] value);
        pause_sender();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        refresh_sb.set_period(value);
        period_writes++;
    endtask

    function automatic logic [PERIOD_W-1:0] period_for_phase(input int phase);
        case (phase)
            0: return 12'd1;
            1: return 12'd2;
            2: return 12'd0;
            3: return 12'd3;
            4: return PERIOD_W'($urandom_range(1, 6));
            5: return 12'd5;
            6: return 12'd1;
            default: return PERIOD_W'($urandom_range(2, 12));
        endcase
    endfunction

    initial begin
        int unsigned pick;
        int          phase;
        int          drain_cycles;
        int unsigned tx_idle_by_mode [4];
        int unsigned rx_stall_by_mode [4];
        logic [KIND_W-1:0]  kind;
        logic [7:0]         ch;
        logic [DIGIT_W-1:0] d;

        tx_idle_by_mode   = '{0, 67, 0, 30};
        rx_stall_by_mode  = '{0, 0, 67, 30};
        refresh_sb        = new();
        tx_idle_pct       = 0;
        rx_stall_pct      = 0;
        rx_hold_off       = 0;
        period_writes     = 0;
        item_if.valid     <= 1'b0;
        item_if.kind      <= KIND_TICK;
        item_if.character <= '0;
        item_if.digit     <= '0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        i_rst_n           <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset period: a short train of ticks stays below it, no refresh
        send_op(KIND_SET_CHAR, "8", 2'd0);
        send_op(KIND_POINT_ON, " ", 2'd0);
        send_ticks(20);
        pause_sender();

        // Directed: every kind, table edges, characters outside the table
        write_period(12'd1);
        send_op(KIND_SET_CHAR, "0", 2'd0);
        send_op(KIND_SET_CHAR, "9", 2'd1);
        send_op(KIND_SET_CHAR, "e", 2'd2);
        send_op(KIND_SET_CHAR, "#", 2'd3);
        send_op(KIND_POINT_ON, 8'hff, 2'd3);
        send_op(KIND_POINT_ON, 8'h00, 2'd1);
        send_op(KIND_SET_CHAR, 8'hff, 2'd1);
        send_ticks(4);
        send_op(KIND_POINT_OFF, "a", 2'd3);
        send_op(KIND_SET_CHAR, 8'h00, 2'd0);
        send_op(KIND_SET_CHAR, "A", 2'd2);
        send_op(KIND_UNKNOWN_FIRST, "1", 2'd3);
        send_op(KIND_UNKNOWN_MID, "2", 2'd0);
        send_op(KIND_UNKNOWN_LAST, "3", 2'd1);
        send_ticks(4);
        send_op(KIND_CLEAR_ALL, "*", 2'd2);
        send_ticks(1);

        // Longest period, then lower it below the running count
        write_period(PERIOD_MAX);
        send_ticks(10);
        write_period(12'd2);
        send_ticks(1);

        // Random phases over several periods and idling mixes
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            write_period(period_for_phase(phase));
            tx_idle_pct  = tx_idle_by_mode[phase % 4];
            rx_stall_pct = rx_stall_by_mode[phase % 4];
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2) pause_sender();
                if ($urandom_range(0, 99) < tx_idle_pct) begin
                    item_if.valid <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end
                pick = $urandom_range(0, 99);
                ch   = 8'($urandom_range(0, 255));
                d    = DIGIT_W'($urandom_range(0, 3));
                if (pick < 50) begin
                    kind = KIND_TICK;
                end else if (pick < 75) begin
                    kind = KIND_SET_CHAR;
                    if ($urandom_range(0, 99) < 70) ch = glyph_chars[$urandom_range(0, 17)];
                end else if (pick < 85) begin
                    kind = KIND_POINT_ON;
                end else if (pick < 93) begin
                    kind = KIND_POINT_OFF;
                end else if (pick < 97) begin
                    kind = KIND_CLEAR_ALL;
                end else begin
                    kind = KIND_W'($urandom_range(KIND_UNKNOWN_FIRST, KIND_UNKNOWN_LAST));
                end
                send_op(kind, ch, d);
            end
        end

        // Hold off the receiver while ticks keep coming so the input stalls
        write_period(12'd1);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_off  = 300;
        send_ticks(40);

        // Drain and look for stray refreshes
        item_if.valid <= 1'b0;
        drain_cycles = 0;
        while (refresh_sb.pending() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);
        refresh_sb.flush_leftovers();

        $display("Run covered %0d items (%0d ticks), %0d refreshes checked,",
                 refresh_sb.item_count, refresh_sb.tick_items, refresh_sb.refresh_count);
        $display("%0d scan-period writes including zero and full scale, %0d mismatches",
                 period_writes, refresh_sb.error_count);
        if (refresh_sb.error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/ssd_pkg.sv
src/ssd_if.sv
src/ssd_in_stage.sv
src/ssd_engine.sv
src/ssd_out_stage.sv
src/seven_segment_scan_driver_core.sv
src/ssd_checker.sv
bench/tb_seven_segment_scan_driver_core.sv
